// File: rtl/kds_pkg.sv
package kds_pkg;

	// field widths of one date
	localparam int YEAR_W = 14;
	localparam int SUB_W  = 7;
	localparam int DATE_W = YEAR_W + 2 * SUB_W;
	localparam int RANK_W = 7;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // take the input item, start the insertion
		logic shift;    // move the entry just read up one place
		logic place;    // write the new date into its slot
		logic publish;  // load the result register and clear the set
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;     // store holds MAX_DATES dates
		logic empty;    // store holds no date
		logic idx_one;  // insertion slot is 1
		logic greater;  // entry read is later than the new date
		logic last;     // current item closes the set
		logic out_free; // result register can take a new item
	} status_t;

endpackage

// File: rtl/kds_ram.sv
module kds_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/kds_ctrl.sv
module kds_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  kds_pkg::status_t status,
	output logic             in_stall,
	output kds_pkg::cmd_t    cmd
);

	import kds_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PLACE,
		ST_SELECT,
		ST_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					priority if (status.full) begin
						// no room: date is dropped
						state_d = ST_SELECT;
					end else if (status.empty) begin
						state_d = ST_PLACE;
					end else begin
						state_d = ST_CMP;
					end
				end
			end
			ST_CMP: begin
				if (status.greater) begin
					cmd.shift = 1'b1;
					state_d   = status.idx_one ? ST_PLACE : ST_CMP;
				end else begin
					cmd.place = 1'b1;
					state_d   = status.last ? ST_SELECT : ST_IDLE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = status.last ? ST_SELECT : ST_IDLE;
			end
			ST_SELECT: begin
				// rank entry is being read; a dropped non-last date ends here
				state_d = status.last ? ST_RESULT : ST_IDLE;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/kds_dp.sv
module kds_dp #(
	parameter int MAX_DATES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kds_pkg::cmd_t               cmd,
	output kds_pkg::status_t            status,
	input  logic [kds_pkg::YEAR_W-1:0]  year,
	input  logic [kds_pkg::SUB_W-1:0]   month,
	input  logic [kds_pkg::SUB_W-1:0]   day,
	input  logic                        last_item,
	input  logic                        cfg_valid,
	input  logic [kds_pkg::RANK_W-1:0]  cfg_data,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [kds_pkg::YEAR_W-1:0]  result_year,
	output logic [kds_pkg::SUB_W-1:0]   result_month,
	output logic [kds_pkg::SUB_W-1:0]   result_day,
	output logic                        found,
	output logic                        overflowed
);

	import kds_pkg::*;

	localparam int AW = $clog2(MAX_DATES);
	localparam int CW = $clog2(MAX_DATES + 1);
	localparam int RW = (AW > RANK_W) ? AW : RANK_W;

	logic [DATE_W-1:0] key_q;
	logic              last_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              overflow_q;
	logic [RANK_W-1:0] rank_q;
	logic              out_valid_q;

	logic [DATE_W-1:0] rd_data;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [DATE_W-1:0] wdata;
	logic              we;
	logic [CW-1:0]     count_m1;
	logic [CW-1:0]     idx_m2;
	logic [RW-1:0]     rank_m1;
	logic              rank_ok;

	assign count_m1 = count_q - CW'(1);
	assign idx_m2   = idx_q - CW'(2);
	assign rank_m1  = RW'(rank_q) - RW'(1);
	assign rank_ok  = (rank_q != '0) && ({{CW{1'b0}}, rank_q} <= {{RANK_W{1'b0}}, count_q});

	// read address: next entry below the slot, or the wanted rank
	always_comb begin
		priority if (cmd.load) begin
			raddr = count_m1[AW-1:0];
		end else if (cmd.shift) begin
			raddr = idx_m2[AW-1:0];
		end else begin
			raddr = rank_m1[AW-1:0];
		end
	end

	// write: shifted entry or the new date at the slot
	assign we    = cmd.shift || cmd.place;
	assign waddr = idx_q[AW-1:0];
	assign wdata = cmd.shift ? rd_data : key_q;

	kds_ram #(
		.WIDTH (DATE_W),
		.DEPTH (MAX_DATES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// status to the controller
	always_comb begin
		status.full     = (count_q == CW'(MAX_DATES));
		status.empty    = (count_q == '0);
		status.idx_one  = (idx_q == CW'(1));
		status.greater  = (rd_data > key_q);
		status.last     = last_q;
		status.out_free = !out_valid_q || !out_stall;
	end

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= {year, month, day};
			last_q <= last_item;
		end
	end

	// slot, count, overflow, rank and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			rank_q      <= RANK_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				rank_q <= cfg_data;
			end
			if (cmd.load) begin
				idx_q <= count_q;
				if (count_q == CW'(MAX_DATES)) begin
					overflow_q <= 1'b1;
				end
			end else if (cmd.shift) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.place) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.publish) begin
				count_q     <= '0;
				overflow_q  <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			result_year  <= rank_ok ? rd_data[DATE_W-1 -: YEAR_W] : '0;
			result_month <= rank_ok ? rd_data[2*SUB_W-1 -: SUB_W] : '0;
			result_day   <= rank_ok ? rd_data[SUB_W-1:0] : '0;
			found        <= rank_ok;
			overflowed   <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/kth_earliest_date_select.sv
// Inserts one date per item into a sorted store held in a single-port-pair RAM.
// A non-last item is compared with the stored dates from the top down; each stored
// date later than it moves up one place (one compare-and-shift per cycle through
// the RAM read/write ports) before it is placed. A last item then reads the wanted
// rank and loads the result. Reset (arst_n low) empties the store, clears overflow,
// sets the rank register to 1; store contents are not cleared, only the count.
module kth_earliest_date_select #(
	parameter int MAX_DATES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [kds_pkg::YEAR_W-1:0]  year,
	input  logic [kds_pkg::SUB_W-1:0]   month,
	input  logic [kds_pkg::SUB_W-1:0]   day,
	input  logic                        last_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [kds_pkg::YEAR_W-1:0]  result_year,
	output logic [kds_pkg::SUB_W-1:0]   result_month,
	output logic [kds_pkg::SUB_W-1:0]   result_day,
	output logic                        found,
	output logic                        overflowed,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kds_pkg::RANK_W-1:0]  cfg_data
);

	import kds_pkg::*;

	cmd_t    cmd;
	status_t status;

	// rank register takes a write at any time
	assign cfg_ready = 1'b1;

	kds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	kds_dp #(
		.MAX_DATES (MAX_DATES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.year         (year),
		.month        (month),
		.day          (day),
		.last_item    (last_item),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.found        (found),
		.overflowed   (overflowed)
	);

endmodule

// File: verif/tb_kth_earliest_date_select.sv
`timescale 1ns / 100ps

module tb_kth_earliest_date_select;
	import kds_pkg::*;

	localparam int MAX_DATES    = 64;
	localparam int DRAIN_CYCLES = MAX_DATES + 16;  // worst insertion plus rank read
	localparam int STUCK_LIMIT  = 4000;            // cycles with no item moving anywhere
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [SUB_W-1:0]  month;
		logic [SUB_W-1:0]  day;
	} date_t;

	typedef struct packed {
		date_t date;
		logic  found;
		logic  overflowed;
	} selection_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [YEAR_W-1:0]   year;
	logic [SUB_W-1:0]    month;
	logic [SUB_W-1:0]    day;
	logic                last_item;
	logic                out_valid;
	logic                out_stall;
	logic [YEAR_W-1:0]   result_year;
	logic [SUB_W-1:0]    result_month;
	logic [SUB_W-1:0]    result_day;
	logic                found;
	logic                overflowed;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [RANK_W-1:0]   cfg_data;

	// predictor state: sorted copy of the set, drop flag, rank register
	date_t               held_dates[$];
	logic                dropped_in_set;
	logic [RANK_W-1:0]   rank_setting;
	selection_t          expected_selections[$];
	selection_t          want;

	int                  errors;
	int                  stuck_cycles;
	int                  tx_gap_pct;
	int                  rx_stall_pct;
	logic                hold_rx;

	kth_earliest_date_select #(
		.MAX_DATES(MAX_DATES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.year         (year),
		.month        (month),
		.day          (day),
		.last_item    (last_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.found        (found),
		.overflowed   (overflowed),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stalls, plus the long hold-off
	always @(posedge clk) begin
		out_stall <= hold_rx || ($urandom_range(0, 99) < rx_stall_pct);
	end

	// watchdog: any item moving on any channel resets the count
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
			$display("tb_kth_earliest_date_select: FAIL");
			$finish;
		end
	end

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// result checker: outputs are stable at the falling edge before acceptance
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_selections.size() == 0) begin
				$display("%0t: result %0d-%0d-%0d found=%0b with none expected", $time,
					result_year, result_month, result_day, found);
				errors++;
			end else begin
				want = expected_selections.pop_front();
				check_field("result_year",  int'(want.date.year),  int'(result_year));
				check_field("result_month", int'(want.date.month), int'(result_month));
				check_field("result_day",   int'(want.date.day),   int'(result_day));
				check_field("found",        int'(want.found),      int'(found));
				check_field("overflowed",   int'(want.overflowed), int'(overflowed));
			end
		end
	end

	// insert into the sorted copy; on a last item form the selection and clear
	task automatic track_date(input date_t key, input logic is_last);
		int         pos;
		selection_t sel;
		if (held_dates.size() >= MAX_DATES) begin
			dropped_in_set = 1'b1;
		end else begin
			pos = 0;
			while (pos < held_dates.size() && held_dates[pos] <= key)
				pos++;
			held_dates.insert(pos, key);
		end
		if (is_last) begin
			sel = '0;
			if (rank_setting >= 1 && int'(rank_setting) <= held_dates.size()) begin
				sel.date  = held_dates[rank_setting - 1];
				sel.found = 1'b1;
			end
			sel.overflowed = dropped_in_set;
			expected_selections.push_back(sel);
			held_dates.delete();
			dropped_in_set = 1'b0;
		end
	endtask

	function automatic date_t make_date(input int y, input int m, input int d);
		date_t dt;
		dt.year  = YEAR_W'(y);
		dt.month = SUB_W'(m);
		dt.day   = SUB_W'(d);
		return dt;
	endfunction

	// mix of full-range fields and a narrow pool that gives ties and near ties
	function automatic date_t rand_date();
		date_t dt;
		if ($urandom_range(0, 99) < 40) begin
			dt.year  = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
			dt.month = SUB_W'($urandom_range(0, (1 << SUB_W) - 1));
			dt.day   = SUB_W'($urandom_range(0, (1 << SUB_W) - 1));
		end else begin
			dt.year  = YEAR_W'($urandom_range(2000, 2003));
			dt.month = SUB_W'($urandom_range(1, 3));
			dt.day   = SUB_W'($urandom_range(1, 4));
		end
		return dt;
	endfunction

	// one item on the input channel; called and returns at a rising edge
	task automatic send_date(input date_t dt, input logic is_last);
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		year      <= dt.year;
		month     <= dt.month;
		day       <= dt.day;
		last_item <= is_last;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		track_date(dt, is_last);
	endtask

	task automatic send_random_set(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_date(rand_date(), i == count - 1);
	endtask

	// all results back, then give any trailing insertion time to finish
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_selections.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rank(input logic [RANK_W-1:0] rank);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= rank;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		rank_setting = rank;
		cfg_valid <= 1'b0;
	endtask

	// extremes of the fields, ties, ordering by year before month before day,
	// rank zero, rank past the count and rank equal to the count
	task automatic test_directed_dates();
		tx_gap_pct   = 23;
		rx_stall_pct = 75;
		send_date(make_date(0, 0, 0), 1'b1);
		send_date(make_date(16383, 127, 127), 1'b1);
		// default rank 1: earliest of a set with a tie
		send_date(make_date(2020, 5, 5), 1'b0);
		send_date(make_date(2020, 5, 5), 1'b0);
		send_date(make_date(1999, 12, 31), 1'b0);
		send_date(make_date(2020, 4, 30), 1'b0);
		send_date(make_date(2020, 5, 4), 1'b1);
		write_rank(3);
		send_date(make_date(100, 0, 0), 1'b0);
		send_date(make_date(99, 127, 127), 1'b0);
		send_date(make_date(99, 127, 126), 1'b0);
		send_date(make_date(99, 0, 127), 1'b0);
		send_date(make_date(100, 0, 0), 1'b1);
		// rank equal to the count
		send_date(make_date(5, 5, 5), 1'b0);
		send_date(make_date(5, 5, 4), 1'b0);
		send_date(make_date(5, 4, 5), 1'b1);
		write_rank(0);
		send_date(make_date(1, 1, 1), 1'b0);
		send_date(make_date(2, 2, 2), 1'b1);
		write_rank(5);
		send_date(make_date(3000, 1, 1), 1'b0);
		send_date(make_date(2999, 12, 1), 1'b0);
		send_date(make_date(3000, 1, 1), 1'b1);
	endtask

	// full store, drops before and on the last item, flag cleared afterwards
	task automatic test_store_overflow();
		tx_gap_pct   = 23;
		rx_stall_pct = 75;
		write_rank(64);
		send_random_set(65);
		write_rank(127);
		send_random_set(MAX_DATES);
		write_rank(64);
		send_random_set(MAX_DATES);
		write_rank(1);
		send_random_set(70);
		send_random_set(3);
	endtask

	task automatic run_random_sets(input int n_items);
		int                sent;
		int                count;
		int                pick;
		logic [RANK_W-1:0] rank;
		sent = 0;
		while (sent < n_items) begin
			count = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 24);
			if ($urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					rank = RANK_W'($urandom_range(1, count));
				else if (pick == 5)
					rank = '0;
				else if (pick == 6)
					rank = RANK_W'(count + 1);
				else if (pick == 7)
					rank = RANK_W'(64);
				else
					rank = RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
				write_rank(rank);
			end
			send_random_set(count);
			sent += count;
		end
	endtask

	task automatic test_random_sets();
		tx_gap_pct   = 23;
		rx_stall_pct = 75;
		run_random_sets(60);
		tx_gap_pct   = 75;
		rx_stall_pct = 23;
		run_random_sets(60);
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		run_random_sets(60);
	endtask

	// receiver holds off while one-date sets keep coming, so the input stalls
	task automatic test_output_backpressure();
		int i;
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		write_rank(1);
		fork
			begin
				@(negedge clk);
				hold_rx = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				@(negedge clk);
				hold_rx = 1'b0;
			end
			begin
				for (i = 0; i < 40; i++)
					send_random_set(1);
			end
		join
		@(posedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		year           = '0;
		month          = '0;
		day            = '0;
		last_item      = 1'b0;
		out_stall      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		hold_rx        = 1'b0;
		tx_gap_pct     = 0;
		rx_stall_pct   = 0;
		errors         = 0;
		stuck_cycles   = 0;
		dropped_in_set = 1'b0;
		rank_setting   = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_dates();
		test_store_overflow();
		test_random_sets();
		test_output_backpressure();

		wait_for_drain();
		if (errors == 0)
			$display("tb_kth_earliest_date_select: PASS");
		else
			$display("tb_kth_earliest_date_select: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/kds_pkg.sv
rtl/kds_ram.sv
rtl/kds_ctrl.sv
rtl/kds_dp.sv
rtl/kth_earliest_date_select.sv
verif/tb_kth_earliest_date_select.sv
